>>> rtl/core/bstk_pkg.sv
// shared types and constants of the bounded stack with sort
package bstk_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_VIEW = 2'd2,
    OP_SORT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_VIEW,
    S_VIEW_END,
    S_SORT_RD,
    S_SORT_V,
    S_SORT_CMP,
    S_SORT_PUT
  } state_e;

  typedef struct packed {
    op_e   op;
    word_t push_value;
  } in_t;

  typedef struct packed {
    status_e status;
    word_t   word;
    logic    last;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    word_t            wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/core/bstk_ram.sv
// entry memory: one write port, one read port, registered read data
module bstk_ram (
  input  logic              clk_i,
  input  bstk_pkg::mem_req_t req_i,
  output bstk_pkg::word_t   rdata_o
);
  import bstk_pkg::*;

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bstk_ctrl.sv
// stack sequencer: push, pop, view walk and insertion sort over the entry memory
module bstk_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bstk_pkg::in_t      item_i,
  output logic               valid_o,
  output bstk_pkg::out_t     result_o,
  output bstk_pkg::mem_req_t mem_req_o,
  input  bstk_pkg::word_t    rdata_i
);
  import bstk_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] j_q, j_d;
  word_t            v_q, v_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             valid_q, valid_d;
  out_t             res_q, res_d;

  logic             accept;
  logic             full;
  logic             empty;
  logic             greater;
  logic             sort_end;
  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] ptr_idx;
  logic [IDX_W-1:0] top_idx;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign greater  = (rdata_i > v_q);
  assign ptr_inc  = ptr_q + CNT_W'(1);
  assign sort_end = (ptr_inc >= cnt_q);
  assign ptr_idx  = ptr_q[IDX_W-1:0];
  assign top_idx  = IDX_W'(cnt_q - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.op)
            OP_POP:  if (!empty) state_d = S_POP;
            OP_VIEW: if (!empty) state_d = S_VIEW;
            OP_SORT: if (cnt_q > CNT_W'(1)) state_d = S_SORT_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP:      state_d = S_IDLE;
      S_VIEW:     if (ptr_q == '0) state_d = S_VIEW_END;
      S_VIEW_END: state_d = S_IDLE;
      S_SORT_RD:  state_d = S_SORT_V;
      S_SORT_V:   state_d = S_SORT_CMP;
      S_SORT_CMP: begin
        if (greater) begin
          if (j_q == IDX_W'(1)) state_d = S_SORT_PUT;
        end else begin
          state_d = sort_end ? S_IDLE : S_SORT_RD;
        end
      end
      S_SORT_PUT: state_d = sort_end ? S_IDLE : S_SORT_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    j_d         = j_q;
    v_d         = v_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    valid_d     = 1'b0;
    res_d       = res_q;
    mem_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.op)
            OP_PUSH: begin
              valid_d = 1'b1;
              if (full) begin
                res_d = '{status: ST_FULL, word: '0, last: 1'b1};
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = cnt_q[IDX_W-1:0];
                mem_req_o.wdata = item_i.push_value;
                cnt_d           = cnt_q + CNT_W'(1);
                res_d           = '{status: ST_OK, word: '0, last: 1'b1};
              end
            end
            OP_POP: begin
              if (empty) begin
                valid_d = 1'b1;
                res_d   = '{status: ST_EMPTY, word: '0, last: 1'b1};
              end else begin
                mem_req_o.raddr = top_idx;
                cnt_d           = cnt_q - CNT_W'(1);
              end
            end
            OP_VIEW: begin
              if (empty) begin
                valid_d = 1'b1;
                res_d   = '{status: ST_EMPTY, word: '0, last: 1'b1};
              end else begin
                ptr_d = cnt_q - CNT_W'(1);
              end
            end
            OP_SORT: begin
              if (empty) begin
                valid_d = 1'b1;
                res_d   = '{status: ST_EMPTY, word: '0, last: 1'b1};
              end else if (cnt_q == CNT_W'(1)) begin
                valid_d = 1'b1;
                res_d   = '{status: ST_OK, word: '0, last: 1'b1};
              end else begin
                ptr_d = CNT_W'(1);
              end
            end
            default: valid_d = 1'b0;
          endcase
        end
      end
      S_POP: begin
        valid_d = 1'b1;
        res_d   = '{status: ST_OK, word: rdata_i, last: 1'b1};
      end
      S_VIEW: begin
        mem_req_o.raddr = ptr_idx;
        pend_d          = 1'b1;
        pend_last_d     = (ptr_q == '0);
        if (ptr_q != '0) ptr_d = ptr_q - CNT_W'(1);
      end
      S_SORT_RD: begin
        mem_req_o.raddr = ptr_idx;
      end
      S_SORT_V: begin
        v_d             = rdata_i;
        j_d             = ptr_idx;
        mem_req_o.raddr = ptr_idx - IDX_W'(1);
      end
      S_SORT_CMP: begin
        mem_req_o.we = 1'b1;
        if (greater) begin
          mem_req_o.waddr = j_q;
          mem_req_o.wdata = rdata_i;
          mem_req_o.raddr = j_q - IDX_W'(2);
          j_d             = j_q - IDX_W'(1);
        end else begin
          mem_req_o.waddr = j_q;
          mem_req_o.wdata = v_q;
          ptr_d           = ptr_inc;
          if (sort_end) begin
            valid_d = 1'b1;
            res_d   = '{status: ST_OK, word: '0, last: 1'b1};
          end
        end
      end
      S_SORT_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = v_q;
        ptr_d           = ptr_inc;
        if (sort_end) begin
          valid_d = 1'b1;
          res_d   = '{status: ST_OK, word: '0, last: 1'b1};
        end
      end
      default: valid_d = 1'b0;
    endcase

    // view data returns in the cycle after its read
    if (pend_q) begin
      valid_d = 1'b1;
      res_d   = '{status: ST_OK, word: rdata_i, last: pend_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> rtl/core/bounded_stack_with_sort.sv
// top level of the bounded stack with in-place descending sort
//
// Input channel: an item (op, push_value) transfers at a rising edge with start
// high and busy low. Results leave on result_o, each valid for exactly one
// cycle with valid_o high; the receiver takes every result and cannot stall.
// Behaviour per operation:
//   push, and any operation on an empty stack: busy stays low
//   pop: busy in S_POP, where the read data of the top entry arrives
//   view of n entries: one result per cycle, top first, last set on the
//     bottom entry; busy through S_VIEW and S_VIEW_END
//   sort of n entries: insertion sort through the single-write entry memory;
//     per entry S_SORT_RD and S_SORT_V read it, S_SORT_CMP shifts each larger
//     entry up one place, S_SORT_PUT or the last compare writes the entry
// The stored words sit in a memory with registered read data; every step that
// needs an entry issues its read address in the state before.
// Reset empties the stack at once; no clearing pass, the words are never
// read before they are written.
module bounded_stack_with_sort (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bstk_pkg::in_t  item_i,
  output logic           valid_o,
  output bstk_pkg::out_t result_o
);
  import bstk_pkg::*;

  mem_req_t mem_req;
  word_t    rdata;

  bstk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .valid_o   (valid_o),
    .result_o  (result_o),
    .mem_req_o (mem_req),
    .rdata_i   (rdata)
  );

  bstk_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule

>>> rtl/core/bstk_chk.sv
// port-level checks of the bounded stack with sort
module bstk_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input bstk_pkg::in_t  item_i,
  input logic           valid_o,
  input bstk_pkg::out_t result_o
);
  import bstk_pkg::*;

  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.op == OP_PUSH |=> valid_o && result_o.last
      && result_o.word == '0)
    else $error("push transfer without its result");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.status != ST_OK |-> result_o.last && result_o.word == '0)
    else $error("error result carries data or is not last");

  a_view_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.last |=> valid_o)
    else $error("gap in view result stream");

  a_view_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.last |-> busy)
    else $error("idle while a view is still streaming");

endmodule

bind bounded_stack_with_sort bstk_chk u_chk (.*);
